// ===== rtl/hta_pkg.sv =====
// hta_pkg: shared types, constants and command codes of the handle table allocator.
// No dependencies.
package hta_pkg;
	localparam int ENTRIES_DEF = 16;
	localparam int ID_BITS_DEF = 16;

	localparam logic [2:0] CMD_OPEN = 3'd0;
	localparam logic [2:0] CMD_CLOSE = 3'd1;
	localparam logic [2:0] CMD_SET_LOCAL = 3'd2;
	localparam logic [2:0] CMD_SET_REMOTE = 3'd3;
	localparam logic [2:0] CMD_SET_CONT = 3'd4;
	localparam logic [2:0] CMD_IS_OPEN = 3'd5;
	localparam logic [2:0] CMD_QUERY = 3'd6;
	localparam logic [2:0] CMD_SPARE = 3'd7;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	localparam logic [7:0] KIND_CONT = 8'd0;
	localparam logic [7:0] KIND_LOCAL = 8'd1;
	localparam logic [7:0] KIND_REMOTE = 8'd2;
	localparam logic [7:0] KIND_UNSET = 8'd255;

	// declared last field first, so cmd lands in the low bits of the word
	typedef struct packed {
		logic [31:0] peer_handle;
		logic [7:0] access_dir;
		logic [31:0] endpoint_num;
		logic [7:0] slot_num;
		logic [15:0] handle;
		logic [2:0] cmd;
	} cmd_t;

	// declared last field first, so status lands in the low bits of the word
	typedef struct packed {
		logic writable;
		logic readable;
		logic [31:0] peer_remote_out;
		logic [31:0] peer_local_out;
		logic [31:0] peer_endpoint_out;
		logic [7:0] peer_slot_out;
		logic [7:0] peer_kind;
		logic is_open;
		logic [15:0] new_handle;
		logic [1:0] status;
	} rsp_t;

	// peer data of one entry: one memory word
	typedef struct packed {
		logic [7:0] kind;
		logic [7:0] pslot;
		logic [31:0] pendpoint;
		logic [31:0] plocal;
		logic [31:0] premote;
	} peer_t;
endpackage

// ===== rtl/handle_table_allocator.sv =====
// Handle table allocator top level: sequencer over key and peer memories.
// Depends on hta_pkg, hta_key_mem, hta_peer_mem.
//
// One command at a time. Every command sweeps the table, one entry a cycle,
// through the key memory's single synchronous read port. Peer set and query
// then read the hit entry's peer word (a read-modify-write for peer set).
// Open sweeps once per candidate id, at most ENTRIES+1 candidates. Live bits
// sit in flip-flops; freed entries read peer data through the live bit and a
// "peer written" bit, so no clearing pass follows reset. The result word
// waits in an output register; the next command is taken the cycle after it
// leaves.
module handle_table_allocator #(
	parameter int ENTRIES = hta_pkg::ENTRIES_DEF,
	parameter int ID_BITS = hta_pkg::ID_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// cmd[2:0], handle[18:3], slot_num[26:19], endpoint_num[58:27],
	// access_dir[66:59], peer_handle[98:67], zero fill
	input logic [103:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// status[1:0], new_handle[17:2], is_open[18], peer_kind[26:19],
	// peer_slot_out[34:27], peer_endpoint_out[66:35], peer_local_out[98:67],
	// peer_remote_out[130:99], readable[131], writable[132], zero fill
	output logic [135:0] m_tdata
);
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = AW + 1;
	localparam int KW = ID_BITS + 48;
	localparam logic [ID_BITS-1:0] ID_MAX = {ID_BITS{1'b1}};
	localparam logic [CW-1:0] LAST = CW'(ENTRIES - 1);
	localparam logic [CW-1:0] NCAND = CW'(ENTRIES);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0] state_q;
	hta_pkg::cmd_t c_q;
	logic [ENTRIES-1:0] used_q, pw_q;
	logic [ID_BITS-1:0] cursor_q, cand_q;
	logic [CW-1:0] idx_q, tries_q;
	logic rd_v_s1;
	logic [AW-1:0] rd_a_s1;
	logic free_found_q, hit_q;
	logic [AW-1:0] free_q, hit_idx_q;
	logic pend_q; // peer read in flight for peer set and query
	hta_pkg::rsp_t rsp_q;
	logic mv_q;

	logic kwe, pwe;
	logic [AW-1:0] kwa, pwa;
	logic [KW-1:0] kwd, krd;
	hta_pkg::peer_t pwd, prd;
	logic [AW-1:0] praddr;

	hta_key_mem #(.ENTRIES(ENTRIES), .ID_BITS(ID_BITS)) u_key (
		.clk(clk), .we(kwe), .waddr(kwa), .wdata(kwd),
		.raddr(idx_q[AW-1:0]), .rdata(krd));
	hta_peer_mem #(.ENTRIES(ENTRIES)) u_peer (
		.clk(clk), .we(pwe), .waddr(pwa), .wdata(pwd),
		.raddr(praddr), .rdata(prd));

	logic [ID_BITS-1:0] k_id;
	logic [7:0] k_slot, k_dir;
	logic [31:0] k_ep;
	logic k_live, id_hit, ks_hit, h_hit, last_rd;
	logic [ID_BITS-1:0] cand_nx;
	logic fr_ok;
	logic [AW-1:0] fr_idx;

	assign k_id = krd[ID_BITS-1:0];
	assign k_slot = krd[ID_BITS+7:ID_BITS];
	assign k_ep = krd[ID_BITS+39:ID_BITS+8];
	assign k_dir = krd[ID_BITS+47:ID_BITS+40];
	assign k_live = rd_v_s1 && used_q[rd_a_s1];
	assign id_hit = k_live && k_id == cand_q;
	assign ks_hit = k_live && k_slot == c_q.slot_num && k_ep == c_q.endpoint_num;
	// full-width compare: handles above the id range never match
	assign h_hit = k_live && c_q.handle != 16'd0 && 32'(k_id) == 32'(c_q.handle);
	assign last_rd = rd_v_s1 && rd_a_s1 == LAST[AW-1:0];
	assign cand_nx = (cand_q >= ID_MAX) ? ID_BITS'(1) : cand_q + ID_BITS'(1);
	// first free entry, including the one read back in this cycle
	assign fr_ok = free_found_q || (rd_v_s1 && !used_q[rd_a_s1]);
	assign fr_idx = free_found_q ? free_q : rd_a_s1;
	// peer read follows the hit in the cycle it is found
	assign praddr = (!hit_q && h_hit) ? rd_a_s1 : hit_idx_q;

	// peer word of the hit entry; KIND_UNSET and zeros until its peer data is written
	hta_pkg::peer_t pcur;
	always_comb begin
		pcur = prd;
		if (!pw_q[hit_idx_q])
			pcur = '{hta_pkg::KIND_UNSET, 8'd0, 32'd0, 32'd0, 32'd0};
	end

	assign s_tready = state_q == S_IDLE && !mv_q;
	assign m_tvalid = mv_q;
	assign m_tdata = {3'd0, rsp_q};

	// key memory written on open; peer memory written on peer set
	always_comb begin
		kwe = 1'b0;
		kwa = fr_idx;
		kwd = {c_q.access_dir, c_q.endpoint_num, c_q.slot_num, cand_q};
		pwe = 1'b0;
		pwa = hit_idx_q;
		pwd = pcur;
		if (state_q == S_SCAN && last_rd && !pend_q) begin
			if (c_q.cmd == hta_pkg::CMD_OPEN)
				kwe = fr_ok && !(id_hit || hit_q);
		end
		if (state_q == S_SCAN && pend_q) begin
			case (c_q.cmd)
				hta_pkg::CMD_SET_LOCAL: begin
					pwe = 1'b1;
					pwd.kind = hta_pkg::KIND_LOCAL;
					pwd.plocal = c_q.peer_handle;
				end
				hta_pkg::CMD_SET_REMOTE: begin
					pwe = 1'b1;
					pwd.kind = hta_pkg::KIND_REMOTE;
					pwd.premote = c_q.peer_handle;
				end
				hta_pkg::CMD_SET_CONT: begin
					pwe = 1'b1;
					pwd.kind = hta_pkg::KIND_CONT;
					pwd.pslot = c_q.slot_num;
					pwd.pendpoint = c_q.endpoint_num;
				end
				default: pwe = 1'b0;
			endcase
		end
	end

	logic [7:0] dir_hit_q, slot_hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			pw_q <= '0;
			cursor_q <= ID_BITS'(1);
			mv_q <= 1'b0;
			rd_v_s1 <= 1'b0;
			pend_q <= 1'b0;
			idx_q <= '0;
		end else begin
			rd_v_s1 <= 1'b0;
			if (mv_q && m_tready)
				mv_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid && !mv_q) begin
						c_q <= s_tdata[98:0];
						idx_q <= '0;
						tries_q <= '0;
						free_found_q <= 1'b0;
						hit_q <= 1'b0;
						pend_q <= 1'b0;
						cand_q <= (cursor_q == '0) ? ID_BITS'(1) : cursor_q;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (pend_q) begin
						// peer word read back for the hit entry
						pend_q <= 1'b0;
						rsp_q <= '0;
						if (pwe)
							pw_q[hit_idx_q] <= 1'b1;
						if (c_q.cmd == hta_pkg::CMD_QUERY) begin
							rsp_q.peer_kind <= pcur.kind;
							rsp_q.peer_slot_out <= pcur.pslot;
							rsp_q.peer_endpoint_out <= pcur.pendpoint;
							rsp_q.peer_local_out <= pcur.plocal;
							rsp_q.peer_remote_out <= pcur.premote;
							if (slot_hit_q == c_q.slot_num) begin
								rsp_q.readable <= dir_hit_q == 8'd1 || dir_hit_q == 8'd2;
								rsp_q.writable <= dir_hit_q == 8'd0 || dir_hit_q == 8'd2;
							end
						end
						state_q <= S_DONE;
					end else begin
						if (idx_q <= LAST) begin
							rd_v_s1 <= 1'b1;
							rd_a_s1 <= idx_q[AW-1:0];
							idx_q <= idx_q + CW'(1);
						end
						if (rd_v_s1) begin
							if (c_q.cmd == hta_pkg::CMD_OPEN) begin
								if (!used_q[rd_a_s1] && !free_found_q) begin
									free_found_q <= 1'b1;
									free_q <= rd_a_s1;
								end
								if (id_hit) hit_q <= 1'b1;
							end else if (c_q.cmd == hta_pkg::CMD_IS_OPEN) begin
								if (ks_hit) hit_q <= 1'b1;
							end else if (h_hit && !hit_q) begin
								hit_q <= 1'b1;
								hit_idx_q <= rd_a_s1;
								dir_hit_q <= k_dir;
								slot_hit_q <= k_slot;
							end
						end
						if (last_rd) begin
							rsp_q <= '0;
							idx_q <= '0;
							state_q <= S_DONE;
							case (c_q.cmd)
								hta_pkg::CMD_OPEN: begin
									if (!fr_ok)
										rsp_q.status <= hta_pkg::ST_FULL;
									else if (!(id_hit || hit_q)) begin
										used_q[fr_idx] <= 1'b1;
										pw_q[fr_idx] <= 1'b0;
										cursor_q <= cand_nx;
										rsp_q.new_handle <= 16'(cand_q);
									end else if (tries_q == NCAND ||
										{1'b0, tries_q} + 1'b1 >= (CW+1)'(ID_MAX)) begin
										rsp_q.status <= hta_pkg::ST_FULL;
									end else begin
										// candidate in use: next id, sweep again
										tries_q <= tries_q + CW'(1);
										cand_q <= cand_nx;
										hit_q <= 1'b0;
										state_q <= S_SCAN;
									end
								end
								hta_pkg::CMD_IS_OPEN:
									rsp_q.is_open <= hit_q || ks_hit;
								hta_pkg::CMD_SPARE: rsp_q <= '0;
								default: begin
									if (!(hit_q || h_hit))
										rsp_q.status <= hta_pkg::ST_NOT_FOUND;
									else if (c_q.cmd == hta_pkg::CMD_CLOSE) begin
										used_q[hit_q ? hit_idx_q : rd_a_s1] <= 1'b0;
									end else begin
										pend_q <= 1'b1;
										state_q <= S_SCAN;
										idx_q <= LAST + CW'(1);
									end
								end
							endcase
						end
					end
				end
				S_DONE: begin
					if (!mv_q || m_tready) begin
						mv_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/hta_peer_mem.sv =====
// hta_peer_mem: peer data memory, one synchronous read port, one write port.
// Depends on hta_pkg.
module hta_peer_mem #(
	parameter int ENTRIES = hta_pkg::ENTRIES_DEF,
	parameter int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input hta_pkg::peer_t wdata,
	input logic [AW-1:0] raddr,
	output hta_pkg::peer_t rdata
);
	hta_pkg::peer_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/hta_key_mem.sv =====
// hta_key_mem: id, slot, endpoint and direction of each entry, synchronous read.
// Depends on hta_pkg.
module hta_key_mem #(
	parameter int ENTRIES = hta_pkg::ENTRIES_DEF,
	parameter int ID_BITS = hta_pkg::ID_BITS_DEF,
	parameter int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	parameter int KW = ID_BITS + 48
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [KW-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [KW-1:0] rdata
);
	logic [KW-1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/hta_checker.sv =====
// hta_port_checker: port-level checks on the handle table allocator, bound to the top.
// Depends on handle_table_allocator ports only.
module hta_port_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [135:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("bad status");
	a_handle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != 2'd0 |-> m_tdata[17:2] == 16'd0)
		else $error("handle on failure");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word taken while busy");
endmodule

bind handle_table_allocator hta_port_checker u_hta_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));

// ===== test/hta_checker.sv =====
// hta_checker: watches both stream channels of the handle table allocator,
// predicts each result word from its own copy of the table and compares.
// Depends on hta_pkg.
module hta_checker
	import hta_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int ID_BITS = ID_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic [103:0] s_tdata,
	input logic m_tvalid,
	input logic m_tready,
	input logic [135:0] m_tdata,
	output int fails,
	output int pending,
	output int n_results
);
	localparam logic [31:0] ID_TOP = (32'd1 << ID_BITS) - 32'd1;

	logic used [ENTRIES];
	logic [31:0] ids [ENTRIES];
	logic [7:0] slots [ENTRIES];
	logic [31:0] endpoints [ENTRIES];
	logic [7:0] dirs [ENTRIES];
	peer_t peers [ENTRIES];
	logic [31:0] cursor;
	rsp_t expected_rsp [$];

	function automatic logic [31:0] next_id(logic [31:0] id);
		return (id >= ID_TOP) ? 32'd1 : id + 32'd1;
	endfunction

	function automatic int lookup(logic [31:0] id);
		if (id == 0) return -1;
		for (int i = 0; i < ENTRIES; i++)
			if (used[i] && ids[i] == id) return i;
		return -1;
	endfunction

	function automatic void wipe(int i);
		used[i] = 1'b0;
		ids[i] = '0;
		slots[i] = '0;
		endpoints[i] = '0;
		peers[i] = '{kind: KIND_UNSET, default: '0};
	endfunction

	// applies one command word to the table copy and returns its answer
	function automatic rsp_t apply_cmd(cmd_t c);
		rsp_t r;
		int e;
		int free_e;
		logic [31:0] cand;
		logic got;
		r = '0;
		free_e = -1;
		got = 1'b0;
		case (c.cmd)
			CMD_OPEN: begin
				for (int i = 0; i < ENTRIES; i++)
					if (!used[i] && free_e < 0) free_e = i;
				if (free_e < 0) begin
					r.status = ST_FULL;
					return r;
				end
				cand = (cursor == 0 || cursor > ID_TOP) ? 32'd1 : cursor;
				for (int k = 0; k < ENTRIES + 1 && k < ID_TOP; k++) begin
					if (lookup(cand) < 0) begin
						got = 1'b1;
						break;
					end
					cand = next_id(cand);
				end
				if (!got) begin
					r.status = ST_FULL;
					return r;
				end
				wipe(free_e);
				used[free_e] = 1'b1;
				ids[free_e] = cand;
				slots[free_e] = c.slot_num;
				endpoints[free_e] = c.endpoint_num;
				dirs[free_e] = c.access_dir;
				cursor = next_id(cand);
				r.new_handle = cand[15:0];
			end
			CMD_IS_OPEN: begin
				for (int i = 0; i < ENTRIES; i++)
					if (used[i] && slots[i] == c.slot_num && endpoints[i] == c.endpoint_num)
						r.is_open = 1'b1;
			end
			CMD_CLOSE, CMD_SET_LOCAL, CMD_SET_REMOTE, CMD_SET_CONT, CMD_QUERY: begin
				e = lookup({16'd0, c.handle});
				if (e < 0) begin
					r.status = ST_NOT_FOUND;
					return r;
				end
				case (c.cmd)
					CMD_CLOSE: wipe(e);
					CMD_SET_LOCAL: begin
						peers[e].kind = KIND_LOCAL;
						peers[e].plocal = c.peer_handle;
					end
					CMD_SET_REMOTE: begin
						peers[e].kind = KIND_REMOTE;
						peers[e].premote = c.peer_handle;
					end
					CMD_SET_CONT: begin
						peers[e].kind = KIND_CONT;
						peers[e].pslot = c.slot_num;
						peers[e].pendpoint = c.endpoint_num;
					end
					default: begin
						r.peer_kind = peers[e].kind;
						r.peer_slot_out = peers[e].pslot;
						r.peer_endpoint_out = peers[e].pendpoint;
						r.peer_local_out = peers[e].plocal;
						r.peer_remote_out = peers[e].premote;
						if (slots[e] == c.slot_num) begin
							r.readable = (dirs[e] == 8'd1 || dirs[e] == 8'd2);
							r.writable = (dirs[e] == 8'd0 || dirs[e] == 8'd2);
						end
					end
				endcase
			end
			default: ; // spare code: no effect
		endcase
		return r;
	endfunction

	function automatic rsp_t unpack_rsp(logic [135:0] d);
		rsp_t r;
		r.status = d[1:0];
		r.new_handle = d[17:2];
		r.is_open = d[18];
		r.peer_kind = d[26:19];
		r.peer_slot_out = d[34:27];
		r.peer_endpoint_out = d[66:35];
		r.peer_local_out = d[98:67];
		r.peer_remote_out = d[130:99];
		r.readable = d[131];
		r.writable = d[132];
		return r;
	endfunction

	function automatic cmd_t unpack_cmd(logic [103:0] d);
		cmd_t c;
		c.cmd = d[2:0];
		c.handle = d[18:3];
		c.slot_num = d[26:19];
		c.endpoint_num = d[58:27];
		c.access_dir = d[66:59];
		c.peer_handle = d[98:67];
		return c;
	endfunction

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		rsp_t got;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				wipe(i);
				dirs[i] = '0;
			end
			cursor = 32'd1;
			expected_rsp.delete();
			fails = 0;
			n_results = 0;
			pending = 0;
		end else begin
			// output side first: a result never leaves in its own command's cycle
			if (m_tvalid && m_tready) begin
				got = unpack_rsp(m_tdata);
				n_results++;
				if (expected_rsp.size() == 0) begin
					$error("result word with nothing expected: %h", m_tdata);
					fails++;
				end else begin
					want = expected_rsp.pop_front();
					compare_field("status", want.status, got.status);
					compare_field("new_handle", want.new_handle, got.new_handle);
					compare_field("is_open", want.is_open, got.is_open);
					compare_field("peer_kind", want.peer_kind, got.peer_kind);
					compare_field("peer_slot_out", want.peer_slot_out, got.peer_slot_out);
					compare_field("peer_endpoint_out", want.peer_endpoint_out,
						got.peer_endpoint_out);
					compare_field("peer_local_out", want.peer_local_out, got.peer_local_out);
					compare_field("peer_remote_out", want.peer_remote_out,
						got.peer_remote_out);
					compare_field("readable", want.readable, got.readable);
					compare_field("writable", want.writable, got.writable);
				end
			end
			if (s_tvalid && s_tready)
				expected_rsp.push_back(apply_cmd(unpack_cmd(s_tdata)));
			pending = expected_rsp.size();
		end
	end
endmodule

// ===== test/tb.sv =====
// tb: stimulus and verdict for the handle table allocator.
// Depends on hta_pkg, handle_table_allocator and hta_checker.
module tb;
	import hta_pkg::*;

	localparam int LIMIT = 2_000_000;	// cycles; slowest run is far below

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [103:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [135:0] m_tdata;
	int fails, pending, n_results;
	int cycles = 0;
	int stall_mode = 0;	// receiver pattern selector
	int gap_left = 0;	// sender gap still to sit out
	int burst_left = 0;
	logic [15:0] live_ids [$];	// handles believed open, for aimed commands
	logic [7:0] last_slot;
	logic [31:0] last_ep;

	always #2 clk = ~clk;

	handle_table_allocator DUT (.*);

	hta_checker checker_i (.*);

	// timeout guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// receiver: switches between always-ready, random and long-stall patterns
	always @(posedge clk) begin
		if (cycles % 3000 == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 2) != 0);
			default: m_tready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	// one word onto the input channel, with burst/gap idling before it
	task automatic send_word(cmd_t c);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap_left = $urandom_range(0, 40) < 10 ? 0 : $urandom_range(1, 30);
			if (gap_left > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap_left) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, c.peer_handle, c.access_dir, c.endpoint_num, c.slot_num,
			c.handle, c.cmd};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (c.cmd == CMD_OPEN) begin
			last_slot = c.slot_num;
			last_ep = c.endpoint_num;
		end
	endtask

	function automatic cmd_t rand_cmd(logic [2:0] op);
		cmd_t c;
		c.cmd = op;
		c.handle = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40));
		if (live_ids.size() > 0 && $urandom_range(0, 3) != 0)
			c.handle = live_ids[$urandom_range(0, live_ids.size() - 1)];
		c.slot_num = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
		c.endpoint_num = $urandom_range(0, 1) ? 32'($urandom_range(0, 3)) : $urandom;
		c.access_dir = $urandom_range(0, 5) == 0 ? 8'($urandom) : 8'($urandom_range(0, 2));
		c.peer_handle = $urandom;
		if (op == CMD_IS_OPEN && $urandom_range(0, 1)) begin
			c.slot_num = last_slot;
			c.endpoint_num = last_ep;
		end
		return c;
	endfunction

	task automatic issue(logic [2:0] op);
		cmd_t c;
		c = rand_cmd(op);
		send_word(c);
		// track handles loosely; the checker holds the real truth
		if (op == CMD_CLOSE)
			foreach (live_ids[i]) if (live_ids[i] == c.handle) begin
				live_ids.delete(i);
				break;
			end
	endtask

	initial begin
		cmd_t c;
		logic [2:0] op;
		last_slot = '0;
		last_ep = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unknown and zero handles, table fill to full, all ops, extremes
		c = '0;
		c.cmd = CMD_QUERY;
		send_word(c);	// handle zero on empty table
		c.cmd = CMD_CLOSE; c.handle = 16'hFFFF;
		send_word(c);
		c = '{cmd: CMD_SPARE, handle: 16'hFFFF, slot_num: 8'hFF, endpoint_num: '1,
			access_dir: 8'hFF, peer_handle: '1};
		send_word(c);	// spare command
		for (int i = 0; i < 17; i++) begin	// 17th open finds the table full
			c = '{cmd: CMD_OPEN, handle: 16'd0, slot_num: 8'(i * 17),
				endpoint_num: (i == 0) ? 32'hFFFF_FFFF : 32'(i),
				access_dir: (i == 3) ? 8'hFF : 8'(i % 3), peer_handle: '1};
			send_word(c);
		end
		for (int i = 1; i <= 16; i++) live_ids.push_back(16'(i));
		c = '{cmd: CMD_SET_LOCAL, handle: 16'd1, slot_num: 8'd0, endpoint_num: '0,
			access_dir: '0, peer_handle: 32'hFFFF_FFFF};
		send_word(c);
		c.cmd = CMD_SET_REMOTE; c.peer_handle = 32'h8000_0001;
		send_word(c);
		c = '{cmd: CMD_SET_CONT, handle: 16'd2, slot_num: 8'hFF, endpoint_num: '1,
			access_dir: '0, peer_handle: '0};
		send_word(c);
		c = '{cmd: CMD_IS_OPEN, handle: 16'd0, slot_num: 8'd0, endpoint_num: '1,
			access_dir: '0, peer_handle: '0};
		send_word(c);
		c = '{cmd: CMD_QUERY, handle: 16'd1, slot_num: 8'd0, endpoint_num: '0,
			access_dir: '0, peer_handle: '0};
		send_word(c);
		c.handle = 16'd4; c.slot_num = 8'd51;	// direction above 2
		send_word(c);
		c.cmd = CMD_CLOSE; c.handle = 16'd1;
		send_word(c);
		c.cmd = CMD_QUERY;	// closed handle now unknown
		send_word(c);
		live_ids.delete(0);

		// random: mostly opens, peer sets and queries on live handles
		for (int n = 0; n < 900; n++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3: op = CMD_OPEN;
				4, 5, 6: op = CMD_CLOSE;
				7, 8: op = CMD_SET_LOCAL;
				9, 10: op = CMD_SET_REMOTE;
				11, 12: op = CMD_SET_CONT;
				13, 14: op = CMD_IS_OPEN;
				19: op = CMD_SPARE;
				default: op = CMD_QUERY;
			endcase
			issue(op);
			// opens: learn the granted id from cursor-free guess; aim later by range
			if (op == CMD_OPEN && live_ids.size() < 16)
				live_ids.push_back(16'($urandom_range(1, 64)));
		end
		s_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("covered %0d result words: open to full, close, peer sets, is-open, query,",
			n_results);
		$display("unknown and zero handles, spare command, bursty input and stalled output");
		if (fails == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/hta_pkg.sv
rtl/hta_peer_mem.sv
rtl/hta_key_mem.sv
rtl/handle_table_allocator.sv
rtl/hta_checker.sv
test/hta_checker.sv
test/tb.sv
